@@ rtl/core/bdq_pkg.sv @@
// Shared constants and codes for the bounded deque with remove-by-value.
// Standalone package; imported by bounded_deque_with_remove.
`timescale 1ns / 1ps

package bdq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int OP_W     = 3;
    localparam int STAT_W   = 2;
    localparam int ECNT_W   = 5;

    // stream beat widths, padded up to whole bytes
    localparam int S_BITS   = OP_W + VAL_W;
    localparam int S_DATA_W = ((S_BITS + 7) / 8) * 8;
    localparam int M_BITS   = VAL_W + STAT_W + ECNT_W;
    localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR     = 3'd0,
        OP_PUSH_TAIL = 3'd1,
        OP_POP_HEAD  = 3'd2,
        OP_POP_TAIL  = 3'd3,
        OP_REMOVE    = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

endpackage

@@ rtl/core/bounded_deque_with_remove.sv @@
// Bounded deque of signed 32-bit values: push tail, pop head/tail, remove by value.
// Depends on bdq_pkg for capacity, widths and operation/status codes.
`timescale 1ns / 1ps

//  channel | dir | handshake              | payload
//  s_      | in  | s_tvalid / s_tready    | s_tdata: operation, value
//  m_      | out | m_tvalid / m_tready    | m_tdata: removed_value, status, entry_count
//
// Clear, push, unused codes and pops/remove on an empty deque go straight from
// accept to the result state.
// Pops and remove walk the entry memory through its single read port: one read
// per cycle for the search, then, after a match, one move per cycle closing the
// gap; a miss ends when the search reaches the last entry.
// aresetn (synchronous) empties the deque; entry memory is not cleared.
// s_tready is high only while the sequencer idles; a result held by a stalled
// m_tready does not block the next accept, only that item's result.

module bounded_deque_with_remove (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [2:0] operation, [34:3] value, upper bits zero
    input  logic [bdq_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] removed_value, [33:32] status, [38:34] entry_count, upper bits zero
    output logic [bdq_pkg::M_DATA_W-1:0]   m_tdata
);

    import bdq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     ptr_reg;
    logic [CNT_W-1:0]     rd_idx_reg;
    logic                 rd_vld_reg;
    logic [VAL_W-1:0]     rd_data_reg;
    op_t                  op_reg;
    logic [VAL_W-1:0]     value_reg;
    logic [VAL_W-1:0]     removed_reg;
    status_t              status_reg;
    logic                 m_valid_reg;
    logic [VAL_W-1:0]     out_removed_reg;
    status_t              out_status_reg;
    logic [CNT_W-1:0]     out_count_reg;

    logic [VAL_W-1:0]     mem [CAPACITY];

    op_t                  in_op;
    logic [VAL_W-1:0]     in_value;
    logic                 s_accept;
    logic                 rd_en;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [VAL_W-1:0]     wr_data;
    logic [CNT_W-1:0]     shift_addr;
    logic                 take_any;
    logic                 is_full;
    logic [CNT_W+ECNT_W-1:0] count_ext;

    assign in_op     = op_t'(s_tdata[OP_W-1:0]);
    assign in_value  = s_tdata[OP_W +: VAL_W];
    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    // pops take the first entry read; remove needs a match
    assign take_any  = (op_reg != OP_REMOVE);

    // one read per cycle while walking the stored entries
    assign rd_en = ((state_reg == S_SEARCH) || (state_reg == S_SHIFT)) && (ptr_reg < count_reg);

    assign shift_addr = rd_idx_reg - 1'b1;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = count_reg[IDX_W-1:0];
        wr_data = in_value;
        if (state_reg == S_SHIFT && rd_vld_reg) begin
            wr_en   = 1'b1;
            wr_addr = shift_addr[IDX_W-1:0];
            wr_data = rd_data_reg;
        end else if (s_accept && in_op == OP_PUSH_TAIL && !is_full) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[ptr_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rd_vld_reg <= rd_en;
            if (rd_en) begin
                rd_idx_reg <= ptr_reg;
                ptr_reg    <= ptr_reg + 1'b1;
            end
            // in S_DONE the next beat takes over the output register
            if (m_valid_reg && m_tready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg      <= in_op;
                        value_reg   <= in_value;
                        removed_reg <= '0;
                        status_reg  <= ST_OK;
                        state_reg   <= S_DONE;
                        case (in_op)
                            OP_CLEAR: begin
                                count_reg <= '0;
                            end
                            OP_PUSH_TAIL: begin
                                if (is_full) begin
                                    status_reg <= ST_FULL;
                                end else begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            OP_POP_HEAD, OP_POP_TAIL, OP_REMOVE: begin
                                if (count_reg == '0) begin
                                    status_reg <= ST_EMPTY;
                                end else begin
                                    ptr_reg   <= (in_op == OP_POP_TAIL) ?
                                                 count_reg - 1'b1 : '0;
                                    state_reg <= S_SEARCH;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SEARCH: begin
                    if (rd_vld_reg) begin
                        if (take_any || rd_data_reg == value_reg) begin
                            // read of the next entry, if any, is already in flight
                            removed_reg <= rd_data_reg;
                            state_reg   <= S_SHIFT;
                        end else if (rd_idx_reg == count_reg - 1'b1) begin
                            status_reg <= ST_NOT_FOUND;
                            state_reg  <= S_DONE;
                        end
                    end
                end
                S_SHIFT: begin
                    if (!rd_en && !rd_vld_reg) begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg     <= 1'b1;
                        out_removed_reg <= removed_reg;
                        out_status_reg  <= status_reg;
                        out_count_reg   <= count_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // entry_count shows the count modulo 32
    assign count_ext = {{ECNT_W{1'b0}}, out_count_reg};

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - M_BITS){1'b0}},
                       count_ext[ECNT_W-1:0], out_status_reg, out_removed_reg};

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for bounded_deque_with_remove: directed corner cases, then
// random deque traffic, with idling on the stream channels; a scoreboard tracks the deque.
// Depends on bdq_pkg and bounded_deque_with_remove from the RTL.
`timescale 1ns / 1ps

module tb_top;
    import bdq_pkg::*;

    localparam int CLK_HALF    = 2;
    localparam int RESET_LEN   = 12;
    localparam int TAIL_CYCLES = 2 * CAPACITY + 12;
    localparam int CYCLE_LIMIT = 600_000;
    localparam int PHASE_ITEMS = 360;
    localparam int BLOCK_ITEMS = 40;

    typedef struct {
        logic [VAL_W-1:0]  removed;
        status_t           status;
        logic [ECNT_W-1:0] cnt;
    } deque_result_t;

    // Holds a shadow copy of the deque and the results it owes, oldest first.
    class deque_scoreboard;
        logic [VAL_W-1:0] store [CAPACITY];
        int unsigned      fill;
        deque_result_t    owed_results[$];
        int               errors;

        function logic [VAL_W-1:0] take_at(int unsigned pos);
            logic [VAL_W-1:0] v;
            v = store[pos];
            for (int unsigned i = pos; i + 1 < fill; i++)
                store[i] = store[i + 1];
            fill--;
            return v;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [VAL_W-1:0] val);
            deque_result_t r;
            r.removed = '0;
            r.status  = ST_OK;
            case (op)
                OP_CLEAR: fill = 0;
                OP_PUSH_TAIL: begin
                    if (fill >= CAPACITY) begin
                        r.status = ST_FULL;
                    end else begin
                        store[fill] = val;
                        fill++;
                    end
                end
                OP_POP_HEAD, OP_POP_TAIL: begin
                    if (fill == 0)
                        r.status = ST_EMPTY;
                    else
                        r.removed = take_at(op == OP_POP_HEAD ? 0 : fill - 1);
                end
                OP_REMOVE: begin
                    if (fill == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.status = ST_NOT_FOUND;
                        for (int unsigned i = 0; i < fill; i++) begin
                            if (store[i] == val) begin
                                r.removed = take_at(i);
                                r.status  = ST_OK;
                                break;
                            end
                        end
                    end
                end
                default: ;  // unused codes leave the deque alone
            endcase
            r.cnt = ECNT_W'(fill);
            owed_results.push_back(r);
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data);
            deque_result_t e;
            if (owed_results.size() == 0) begin
                $display("%0t unexpected result beat %h", $time, data);
                errors++;
                return;
            end
            e = owed_results.pop_front();
            if (data[31:0] !== e.removed) begin
                $display("%0t removed_value exp %h got %h", $time, e.removed, data[31:0]);
                errors++;
            end
            if (data[33:32] !== e.status) begin
                $display("%0t status exp %0d got %0d", $time, e.status, data[33:32]);
                errors++;
            end
            if (data[38:34] !== e.cnt) begin
                $display("%0t entry_count exp %0d got %0d", $time, e.cnt, data[38:34]);
                errors++;
            end
        endfunction
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    deque_scoreboard sb = new();
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    int              cycles         = 0;

    bounded_deque_with_remove u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL bounded_deque_with_remove");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Holds the beat until accepted; tvalid stays high into the next item unless it idles.
    task automatic send_item(logic [OP_W-1:0] op, logic [VAL_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({val, op});
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, val);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.owed_results.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // Small pool gives duplicates and sign extremes; otherwise a full 32-bit draw.
    function automatic logic [VAL_W-1:0] pick_value(bit from_store);
        int unsigned sel;
        sel = $urandom_range(99);
        if (from_store && sb.fill != 0 && sel < 60)
            return sb.store[$urandom_range(sb.fill - 1)];
        if (sel < 80) begin
            case ($urandom_range(6))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                default: return VAL_W'($urandom_range(4));
            endcase
        end
        return $urandom;
    endfunction

    task automatic random_phase(int idle_pct, int stall_pct);
        int          push_w;
        int unsigned r;
        logic [OP_W-1:0] op;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % BLOCK_ITEMS == 0) begin
                // fill-heavy, drain-heavy or balanced stretches; some without idling
                case ($urandom_range(2))
                    0: push_w = 70;
                    1: push_w = 20;
                    default: push_w = 45;
                endcase
                send_idle_pct  = ($urandom_range(4) == 0) ? 0 : idle_pct;
                recv_stall_pct = ($urandom_range(4) == 0) ? 0 : stall_pct;
            end
            r = $urandom_range(99);
            if (r < 2)
                op = OP_CLEAR;
            else if (r < 4)
                op = OP_W'($urandom_range(7, 5));
            else if (r < 4 + push_w)
                op = OP_PUSH_TAIL;
            else
                case ($urandom_range(2))
                    0: op = OP_POP_HEAD;
                    1: op = OP_POP_TAIL;
                    default: op = OP_REMOVE;
                endcase
            send_item(op, pick_value(op == OP_REMOVE));
        end
    endtask

    initial begin
        repeat (RESET_LEN) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty deque, sign extremes, duplicates, misses, unused codes
        send_item(OP_POP_HEAD, 32'h0);
        send_item(OP_POP_TAIL, 32'h0);
        send_item(OP_REMOVE, 32'h0);
        send_item(OP_PUSH_TAIL, 32'h8000_0000);
        send_item(OP_PUSH_TAIL, 32'h7FFF_FFFF);
        send_item(OP_PUSH_TAIL, 32'h0);
        send_item(OP_PUSH_TAIL, 32'hFFFF_FFFF);
        send_item(OP_PUSH_TAIL, 32'd7);
        send_item(OP_PUSH_TAIL, 32'd7);
        send_item(OP_REMOVE, 32'd7);
        send_item(OP_REMOVE, 32'd12345);
        send_item(OP_W'(5), 32'hFFFF_FFFF);
        send_item(OP_W'(6), 32'h0);
        send_item(OP_W'(7), 32'hFFFF_FFFF);
        send_item(OP_POP_HEAD, 32'h0);
        send_item(OP_POP_TAIL, 32'h0);
        send_item(OP_REMOVE, 32'h0);
        send_item(OP_CLEAR, 32'hFFFF_FFFF);
        send_item(OP_POP_HEAD, 32'h0);
        // fill past capacity so a push is refused
        for (int i = 0; i <= CAPACITY; i++)
            send_item(OP_PUSH_TAIL, VAL_W'(i));
        wait_idle();

        random_phase(0, 0);
        wait_idle();
        random_phase(62, 0);
        wait_idle();
        random_phase(0, 62);
        wait_idle();
        random_phase(10, 10);
        wait_idle();

        if (sb.errors == 0 && sb.owed_results.size() == 0)
            $display("PASS bounded_deque_with_remove");
        else
            $display("FAIL bounded_deque_with_remove");
        $finish;
    end

endmodule
